FILE: hdl/vte_pkg.sv
// Version token extractor: shared types, character constants and helpers.
// No dependencies; used by every file in hdl/ but vte_ram.
package vte_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_HYPHEN = 8'h2d;
  localparam logic [3:0] KEY_LEN   = 4'd9;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_COLON = 3'd1,
    ST_NO_OPENQ = 3'd2,
    ST_UNTERM   = 3'd3,
    ST_BAD_LEN  = 3'd4,
    ST_ILLEGAL  = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    KP_SEARCH  = 5'b00001,
    KP_COLON   = 5'b00010,
    KP_OPENQ   = 5'b00100,
    KP_CAPTURE = 5'b01000,
    KP_DONE    = 5'b10000
  } key_phase_t;

  typedef enum logic [3:0] {
    BP_SKIP   = 4'b0001,
    BP_QUOTED = 4'b0010,
    BP_RUN    = 4'b0100,
    BP_DONE   = 4'b1000
  } bare_phase_t;

  typedef struct packed {
    logic    key_path;
    logic    bank;
    status_t status;
  } run_desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  typedef struct packed {
    logic [7:0] token_char;
    logic [4:0] token_length;
    status_t    parse_status;
    logic       run_last;
  } result_t;

  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = CH_QUOTE;
      4'd1:    c = 8'h76;
      4'd2:    c = 8'h65;
      4'd3:    c = 8'h72;
      4'd4:    c = 8'h73;
      4'd5:    c = 8'h69;
      4'd6:    c = 8'h6f;
      4'd7:    c = 8'h6e;
      4'd8:    c = CH_QUOTE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_legal(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a) || c == CH_DOT || c == CH_UNDER ||
           c == CH_HYPHEN;
  endfunction

endpackage

FILE: hdl/vte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/vte_front.sv
// Front end: accepts body bytes, runs the key and bare parsers, writes
// captured characters to the token RAMs and queues one descriptor per run.
// Depends on vte_pkg.
module vte_front #(
  parameter int BODY_MAX    = 256,
  parameter int VERSION_MAX = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [7:0]                          body_byte,
  input  logic                                body_last,
  input  vte_pkg::bank_rel_t                  rel,
  output logic                                key_we,
  output logic                                bare_we,
  output logic [$clog2(VERSION_MAX):0]        key_waddr,
  output logic [$clog2(VERSION_MAX):0]        bare_waddr,
  output logic                                q_push,
  output vte_pkg::run_desc_t                  q_desc,
  output logic [$clog2(VERSION_MAX+1)-1:0]    q_len,
  input  logic                                q_full
);

  localparam int IW  = $clog2(VERSION_MAX);
  localparam int LW  = $clog2(VERSION_MAX + 1);
  localparam int BCW = $clog2(BODY_MAX);

  logic [BCW-1:0]       byte_count_r, byte_count_nxt;
  logic                 text_ended_r, text_ended_nxt;
  logic [3:0]           key_pos_r, key_pos_nxt;
  vte_pkg::key_phase_t  key_phase_r, key_phase_nxt;
  logic [LW-1:0]        key_len_r, key_len_nxt;
  logic                 key_bad_r, key_bad_nxt;
  vte_pkg::bare_phase_t bare_phase_r, bare_phase_nxt;
  logic [LW-1:0]        bare_len_r, bare_len_nxt;
  logic                 bare_bad_r, bare_bad_nxt;
  logic                 bank_r;
  logic [1:0]           busy_r, busy_nxt;

  logic                 accept, live, feed, run_end;
  logic                 key_sel, sel_bad;
  logic [LW-1:0]        sel_len;
  vte_pkg::status_t     status;

  assign full    = busy_r[bank_r] || q_full;
  assign accept  = push && !full;
  assign live    = accept && !text_ended_r && (byte_count_r < BCW'(BODY_MAX - 1));
  assign feed    = live && (body_byte != 8'h00);
  assign run_end = accept && body_last;

  assign key_waddr  = {bank_r, key_len_r[IW-1:0]};
  assign bare_waddr = {bank_r, bare_len_r[IW-1:0]};

  always_comb begin
    key_pos_nxt   = key_pos_r;
    key_phase_nxt = key_phase_r;
    key_len_nxt   = key_len_r;
    key_bad_nxt   = key_bad_r;
    key_we        = 1'b0;
    if (feed) begin
      unique case (key_phase_r)
        vte_pkg::KP_SEARCH: begin
          if (key_pos_r < vte_pkg::KEY_LEN && body_byte == vte_pkg::key_char(key_pos_r)) begin
            key_pos_nxt = key_pos_r + 4'd1;
          end else begin
            key_pos_nxt = (body_byte == vte_pkg::CH_QUOTE) ? 4'd1 : 4'd0;
          end
          if (key_pos_nxt >= vte_pkg::KEY_LEN) begin
            key_phase_nxt = vte_pkg::KP_COLON;
          end
        end
        vte_pkg::KP_COLON: begin
          if (body_byte == vte_pkg::CH_COLON) begin
            key_phase_nxt = vte_pkg::KP_OPENQ;
          end
        end
        vte_pkg::KP_OPENQ: begin
          if (body_byte == vte_pkg::CH_QUOTE) begin
            key_phase_nxt = vte_pkg::KP_CAPTURE;
          end
        end
        vte_pkg::KP_CAPTURE: begin
          if (body_byte == vte_pkg::CH_QUOTE) begin
            key_phase_nxt = vte_pkg::KP_DONE;
          end else begin
            if (key_len_r < LW'(VERSION_MAX)) begin
              key_we      = key_len_r < LW'(VERSION_MAX - 1);
              key_len_nxt = key_len_r + LW'(1);
            end
            if (!vte_pkg::is_legal(body_byte)) begin
              key_bad_nxt = 1'b1;
            end
          end
        end
        vte_pkg::KP_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    logic grab;
    grab           = 1'b0;
    bare_phase_nxt = bare_phase_r;
    bare_len_nxt   = bare_len_r;
    bare_bad_nxt   = bare_bad_r;
    bare_we        = 1'b0;
    if (feed) begin
      unique case (bare_phase_r)
        vte_pkg::BP_SKIP: begin
          if (!vte_pkg::is_space(body_byte)) begin
            if (body_byte == vte_pkg::CH_QUOTE) begin
              bare_phase_nxt = vte_pkg::BP_QUOTED;
            end else begin
              bare_phase_nxt = vte_pkg::BP_RUN;
              grab           = 1'b1;
            end
          end
        end
        vte_pkg::BP_QUOTED: begin
          if (body_byte == vte_pkg::CH_QUOTE) begin
            bare_phase_nxt = vte_pkg::BP_DONE;
          end else begin
            grab = 1'b1;
          end
        end
        vte_pkg::BP_RUN: begin
          if (vte_pkg::is_space(body_byte)) begin
            bare_phase_nxt = vte_pkg::BP_DONE;
          end else begin
            grab = 1'b1;
          end
        end
        vte_pkg::BP_DONE: begin
        end
        default: begin
        end
      endcase
    end
    if (grab) begin
      if (bare_len_r < LW'(VERSION_MAX)) begin
        bare_we      = bare_len_r < LW'(VERSION_MAX - 1);
        bare_len_nxt = bare_len_r + LW'(1);
      end
      if (!vte_pkg::is_legal(body_byte)) begin
        bare_bad_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    key_sel = key_phase_nxt != vte_pkg::KP_SEARCH;
    if (key_sel) begin
      sel_len = key_len_nxt;
      sel_bad = key_bad_nxt;
      priority if (key_phase_nxt == vte_pkg::KP_COLON) begin
        status = vte_pkg::ST_NO_COLON;
      end else if (key_phase_nxt == vte_pkg::KP_OPENQ) begin
        status = vte_pkg::ST_NO_OPENQ;
      end else if (key_phase_nxt == vte_pkg::KP_CAPTURE) begin
        status = vte_pkg::ST_UNTERM;
      end else begin
        status = vte_pkg::ST_OK;
      end
    end else begin
      sel_len = bare_len_nxt;
      sel_bad = bare_bad_nxt;
      status  = (bare_phase_nxt == vte_pkg::BP_QUOTED) ? vte_pkg::ST_UNTERM : vte_pkg::ST_OK;
    end
    if (status == vte_pkg::ST_OK && (sel_len == '0 || sel_len >= LW'(VERSION_MAX))) begin
      status = vte_pkg::ST_BAD_LEN;
    end
    if (status == vte_pkg::ST_OK && sel_bad) begin
      status = vte_pkg::ST_ILLEGAL;
    end
  end

  assign q_push          = run_end;
  assign q_desc.key_path = key_sel;
  assign q_desc.bank     = bank_r;
  assign q_desc.status   = status;
  assign q_len           = sel_len;

  always_comb begin
    byte_count_nxt = byte_count_r;
    text_ended_nxt = text_ended_r;
    if (live) begin
      if (body_byte == 8'h00) begin
        text_ended_nxt = 1'b1;
      end else begin
        byte_count_nxt = byte_count_r + BCW'(1);
      end
    end
    busy_nxt = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (run_end) begin
      busy_nxt[bank_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || run_end) begin
      byte_count_r <= '0;
      text_ended_r <= 1'b0;
      key_pos_r    <= 4'd0;
      key_phase_r  <= vte_pkg::KP_SEARCH;
      key_len_r    <= '0;
      key_bad_r    <= 1'b0;
      bare_phase_r <= vte_pkg::BP_SKIP;
      bare_len_r   <= '0;
      bare_bad_r   <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      text_ended_r <= text_ended_nxt;
      key_pos_r    <= key_pos_nxt;
      key_phase_r  <= key_phase_nxt;
      key_len_r    <= key_len_nxt;
      key_bad_r    <= key_bad_nxt;
      bare_phase_r <= bare_phase_nxt;
      bare_len_r   <= bare_len_nxt;
      bare_bad_r   <= bare_bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      busy_r <= 2'b00;
    end else begin
      bank_r <= bank_r ^ run_end;
      busy_r <= busy_nxt;
    end
  end

endmodule

FILE: hdl/vte_desc_q.sv
// Two-entry queue of run descriptors between front and back end.
// Depends on vte_pkg.
module vte_desc_q #(
  parameter int LEN_W = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  vte_pkg::run_desc_t din_desc,
  input  logic [LEN_W-1:0]   din_len,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output vte_pkg::run_desc_t dout_desc,
  output logic [LEN_W-1:0]   dout_len
);

  vte_pkg::run_desc_t desc_r [2];
  logic [LEN_W-1:0]   len_r  [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         cnt_r;
  logic               do_push, do_pop;

  assign full      = cnt_r == 2'd2;
  assign empty     = cnt_r == 2'd0;
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign dout_desc = desc_r[rd_ptr_r];
  assign dout_len  = len_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      desc_r[wr_ptr_r] <= din_desc;
      len_r[wr_ptr_r]  <= din_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r ^ do_push;
      rd_ptr_r <= rd_ptr_r ^ do_pop;
      cnt_r    <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

FILE: hdl/vte_back.sv
// Back end: walks each queued run, reads token characters from the RAMs
// and pushes result items into a four-entry output queue.
// Depends on vte_pkg.
module vte_back #(
  parameter int VERSION_MAX = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  vte_pkg::run_desc_t               q_desc,
  input  logic [$clog2(VERSION_MAX+1)-1:0] q_len,
  output logic                             q_pop,
  output vte_pkg::bank_rel_t               rel,
  output logic [$clog2(VERSION_MAX):0]     rd_addr,
  input  logic [7:0]                       key_rdata,
  input  logic [7:0]                       bare_rdata,
  output logic                             out_empty,
  input  logic                             out_pop,
  output vte_pkg::result_t                 out_result
);

  localparam int IW = $clog2(VERSION_MAX);
  localparam int LW = $clog2(VERSION_MAX + 1);

  logic               active_r;
  vte_pkg::run_desc_t cur_desc_r;
  logic [LW-1:0]      cur_len_r;
  logic [LW-1:0]      k_r;

  logic               pend_r;
  logic               pend_key_r;
  logic               pend_fail_r;
  vte_pkg::result_t   pend_item_r;

  vte_pkg::result_t   fifo_r [4];
  logic [1:0]         wr_ptr_r, rd_ptr_r;
  logic [2:0]         cnt_r;

  logic               issue, fail, is_end, do_pop;
  vte_pkg::result_t   wr_item;

  assign q_pop   = !active_r && !q_empty;
  assign fail    = cur_desc_r.status != vte_pkg::ST_OK;
  assign is_end  = fail || (k_r == cur_len_r - LW'(1));
  assign issue   = active_r && ((cnt_r + 3'(pend_r)) < 3'd4);
  assign rd_addr = {cur_desc_r.bank, k_r[IW-1:0]};

  assign rel.valid = issue && is_end;
  assign rel.bank  = cur_desc_r.bank;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      pend_r <= issue;
      if (q_pop) begin
        active_r <= 1'b1;
      end else if (issue && is_end) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_desc_r <= q_desc;
      cur_len_r  <= q_len;
      k_r        <= '0;
    end else if (issue) begin
      k_r <= k_r + LW'(1);
    end
    if (issue) begin
      pend_key_r               <= cur_desc_r.key_path;
      pend_fail_r              <= fail;
      pend_item_r.token_char   <= 8'h00;
      pend_item_r.token_length <= fail ? 5'd0 : 5'(cur_len_r);
      pend_item_r.parse_status <= cur_desc_r.status;
      pend_item_r.run_last     <= is_end;
    end
  end

  always_comb begin
    wr_item = pend_item_r;
    if (!pend_fail_r) begin
      wr_item.token_char = pend_key_r ? key_rdata : bare_rdata;
    end
  end

  assign out_empty  = cnt_r == 3'd0;
  assign do_pop     = out_pop && !out_empty;
  assign out_result = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (pend_r) begin
      fifo_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r + 2'(pend_r);
      rd_ptr_r <= rd_ptr_r + 2'(do_pop);
      cnt_r    <= cnt_r + 3'(pend_r) - 3'(do_pop);
    end
  end

endmodule

FILE: hdl/version_token_extractor_core.sv
// Version token extractor, top level: front end, descriptor queue, back end
// and two double-banked token RAMs.
// Depends on vte_pkg, vte_ram, vte_front, vte_desc_q, vte_back.
//
//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+---------------------
//  input   | in_body_byte, in_body_last                         | in_push / in_full
//  result  | out_token_char, out_token_length, out_parse_status,| out_pop / out_empty
//          | out_run_last                                       |
//
// One body byte per cycle while in_full is low; the parsers update in the cycle the item is taken.
// The back end emits one result per cycle while its output queue has room, with one
// RAM read each, and takes the next run only after the last one ends. Token RAMs
// hold two banks, so a new run may start while the previous one drains; a third
// run waits (in_full) until a bank frees. Reset is synchronous; the RAMs need no
// clearing. A stalled result side backs up through a four-item output queue.
module version_token_extractor_core #(
  parameter int BODY_MAX    = 256,
  parameter int VERSION_MAX = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_body_byte,
  input  logic       in_body_last,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_token_char,
  output logic [4:0] out_token_length,
  output logic [2:0] out_parse_status,
  output logic       out_run_last
);

  localparam int IW    = $clog2(VERSION_MAX);
  localparam int LW    = $clog2(VERSION_MAX + 1);
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 ** AW;

  logic               key_we, bare_we;
  logic [AW-1:0]      key_waddr, bare_waddr, rd_addr;
  logic [7:0]         key_rdata, bare_rdata;
  logic               q_push, q_full, q_pop, q_empty;
  vte_pkg::run_desc_t q_din, q_dout;
  logic [LW-1:0]      q_din_len, q_dout_len;
  vte_pkg::bank_rel_t rel;
  vte_pkg::result_t   result;

  vte_front #(
    .BODY_MAX    (BODY_MAX),
    .VERSION_MAX (VERSION_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .full       (in_full),
    .body_byte  (in_body_byte),
    .body_last  (in_body_last),
    .rel        (rel),
    .key_we     (key_we),
    .bare_we    (bare_we),
    .key_waddr  (key_waddr),
    .bare_waddr (bare_waddr),
    .q_push     (q_push),
    .q_desc     (q_din),
    .q_len      (q_din_len),
    .q_full     (q_full)
  );

  vte_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_body_byte),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  vte_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_bare_ram (
    .clk   (clk),
    .we    (bare_we),
    .waddr (bare_waddr),
    .wdata (in_body_byte),
    .raddr (rd_addr),
    .rdata (bare_rdata)
  );

  vte_desc_q #(
    .LEN_W (LW)
  ) u_desc_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din_desc  (q_din),
    .din_len   (q_din_len),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .dout_desc (q_dout),
    .dout_len  (q_dout_len)
  );

  vte_back #(
    .VERSION_MAX (VERSION_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_desc     (q_dout),
    .q_len      (q_dout_len),
    .q_pop      (q_pop),
    .rel        (rel),
    .rd_addr    (rd_addr),
    .key_rdata  (key_rdata),
    .bare_rdata (bare_rdata),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_result (result)
  );

  assign out_token_char   = result.token_char;
  assign out_token_length = result.token_length;
  assign out_parse_status = result.parse_status;
  assign out_run_last     = result.run_last;

  a_desc_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("descriptor pushed into a full queue");

  a_fail_item_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_parse_status != vte_pkg::ST_OK) |->
      (out_run_last && out_token_length == 5'd0 && out_token_char == 8'h00))
    else $error("failure item not a lone zeroed item");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for version_token_extractor_core: queue-fed driver,
// clocked monitor and an in-bench parser model of both extraction paths.
// Depends on vte_pkg and the RTL under hdl/.
module tb_top;

  localparam int BODY_MAX    = 256;
  localparam int VERSION_MAX = 32;
  localparam int PATH_BARE   = 0;
  localparam int PATH_KEY    = 1;
  localparam int RANDOM_ITEMS = 280;
  localparam string LEGAL_SET =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz._-";
  // "version" including its quotes
  localparam logic [7:0] KEY_WORD [9] = '{vte_pkg::CH_QUOTE, 8'h76, 8'h65, 8'h72, 8'h73,
                                          8'h69, 8'h6f, 8'h6e, vte_pkg::CH_QUOTE};

  typedef struct {
    logic [7:0] b;
    logic       fin;
    bit         drain_first;
  } body_item_t;

  typedef struct {
    logic [7:0]       ch;
    logic [4:0]       len;
    vte_pkg::status_t st;
    logic             fin;
  } token_beat_t;

  logic       clk;
  logic       rst_n;
  logic       in_push      = 1'b0;
  logic       in_full;
  logic [7:0] in_body_byte = 8'h00;
  logic       in_body_last = 1'b0;
  logic       out_empty;
  logic       out_pop      = 1'b0;
  logic [7:0] out_token_char;
  logic [4:0] out_token_length;
  logic [2:0] out_parse_status;
  logic       out_run_last;

  body_item_t  body_q[$];
  token_beat_t token_chars_due[$];
  logic [7:0]  draft[$];
  body_item_t  nxt;
  token_beat_t want;

  int unsigned err_count   = 0;
  int unsigned bytes_taken = 0;
  int unsigned items_total = 0;
  int          burst_left  = 0;
  int          gap_left    = 0;
  int          hold_left   = 0;
  bit          hold_done   = 1'b0;
  int          pop_mode    = 0;
  int          mode_left   = 0;

  // parser model state
  int unsigned          text_bytes   = 0;
  bit                   text_stopped = 1'b0;
  int unsigned          key_pos      = 0;
  vte_pkg::key_phase_t  kph          = vte_pkg::KP_SEARCH;
  vte_pkg::bare_phase_t bph          = vte_pkg::BP_SKIP;
  logic [7:0]           tok_buf [2][VERSION_MAX];
  int unsigned          tok_len [2]  = '{0, 0};
  bit                   tok_bad [2]  = '{1'b0, 1'b0};

  version_token_extractor_core #(
    .BODY_MAX    (BODY_MAX),
    .VERSION_MAX (VERSION_MAX)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_body_byte     (in_body_byte),
    .in_body_last     (in_body_last),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_char   (out_token_char),
    .out_token_length (out_token_length),
    .out_parse_status (out_parse_status),
    .out_run_last     (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic bit ws_char(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic bit version_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           c == vte_pkg::CH_DOT || c == vte_pkg::CH_UNDER || c == vte_pkg::CH_HYPHEN;
  endfunction

  task automatic grab_char(input int p, input logic [7:0] c);
    if (tok_len[p] < VERSION_MAX) begin
      if (tok_len[p] < VERSION_MAX - 1) tok_buf[p][tok_len[p]] = c;
      tok_len[p]++;
    end
    if (!version_char(c)) tok_bad[p] = 1'b1;
  endtask

  task automatic parse_body_byte(input logic [7:0] c, input logic fin);
    int p;
    vte_pkg::status_t st;
    if (!text_stopped && text_bytes < BODY_MAX - 1) begin
      if (c == 8'h00) begin
        text_stopped = 1'b1;
      end else begin
        case (kph)
          vte_pkg::KP_SEARCH: begin
            if (key_pos < vte_pkg::KEY_LEN && c == KEY_WORD[key_pos]) key_pos++;
            else key_pos = (c == vte_pkg::CH_QUOTE) ? 1 : 0;
            if (key_pos >= vte_pkg::KEY_LEN) kph = vte_pkg::KP_COLON;
          end
          vte_pkg::KP_COLON: if (c == vte_pkg::CH_COLON) kph = vte_pkg::KP_OPENQ;
          vte_pkg::KP_OPENQ: if (c == vte_pkg::CH_QUOTE) kph = vte_pkg::KP_CAPTURE;
          vte_pkg::KP_CAPTURE: begin
            if (c == vte_pkg::CH_QUOTE) kph = vte_pkg::KP_DONE;
            else grab_char(PATH_KEY, c);
          end
          default: ;
        endcase
        case (bph)
          vte_pkg::BP_SKIP: begin
            if (!ws_char(c)) begin
              if (c == vte_pkg::CH_QUOTE) bph = vte_pkg::BP_QUOTED;
              else begin
                bph = vte_pkg::BP_RUN;
                grab_char(PATH_BARE, c);
              end
            end
          end
          vte_pkg::BP_QUOTED: begin
            if (c == vte_pkg::CH_QUOTE) bph = vte_pkg::BP_DONE;
            else grab_char(PATH_BARE, c);
          end
          vte_pkg::BP_RUN: begin
            if (ws_char(c)) bph = vte_pkg::BP_DONE;
            else grab_char(PATH_BARE, c);
          end
          default: ;
        endcase
        text_bytes++;
      end
    end
    if (fin) begin
      st = vte_pkg::ST_OK;
      if (kph != vte_pkg::KP_SEARCH) begin
        p = PATH_KEY;
        case (kph)
          vte_pkg::KP_COLON:   st = vte_pkg::ST_NO_COLON;
          vte_pkg::KP_OPENQ:   st = vte_pkg::ST_NO_OPENQ;
          vte_pkg::KP_CAPTURE: st = vte_pkg::ST_UNTERM;
          default:             st = vte_pkg::ST_OK;
        endcase
      end else begin
        p = PATH_BARE;
        if (bph == vte_pkg::BP_QUOTED) st = vte_pkg::ST_UNTERM;
      end
      if (st == vte_pkg::ST_OK && (tok_len[p] == 0 || tok_len[p] >= VERSION_MAX))
        st = vte_pkg::ST_BAD_LEN;
      if (st == vte_pkg::ST_OK && tok_bad[p]) st = vte_pkg::ST_ILLEGAL;
      if (st != vte_pkg::ST_OK) begin
        token_chars_due.push_back(token_beat_t'{8'h00, 5'd0, st, 1'b1});
      end else begin
        for (int k = 0; k < tok_len[p]; k++)
          token_chars_due.push_back(token_beat_t'{tok_buf[p][k], 5'(tok_len[p]),
                                                  vte_pkg::ST_OK, k + 1 == tok_len[p]});
      end
      text_bytes   = 0;
      text_stopped = 1'b0;
      key_pos      = 0;
      kph          = vte_pkg::KP_SEARCH;
      bph          = vte_pkg::BP_SKIP;
      tok_len      = '{0, 0};
      tok_bad      = '{1'b0, 1'b0};
    end
  endtask

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] exp_val);
    if (err_count < 100)
      $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, exp_val);
    err_count++;
  endtask

  // stimulus helpers: build up the draft body and ship it to the body queue
  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endtask

  task automatic put_ws(input int n);
    int idx;
    repeat (n) begin
      idx = $urandom_range(0, 5);
      draft.push_back(idx == 5 ? 8'h20 : 8'(8'h09 + idx));
    end
  endtask

  task automatic put_noise(input int n);
    repeat (n) draft.push_back(8'($urandom_range(1, 255)));
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(30, 31);
    if (r == 2) return $urandom_range(32, 34);
    return $urandom_range(1, 8);
  endfunction

  task automatic put_token(input int n, input bit quoted);
    int bad_at;
    logic [7:0] c;
    bad_at = (n > 0 && $urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == bad_at) begin
        do c = 8'($urandom_range(1, 255));
        while (version_char(c) || c == vte_pkg::CH_QUOTE || (!quoted && ws_char(c)));
      end else begin
        c = LEGAL_SET[$urandom_range(0, 64)];
      end
      draft.push_back(c);
    end
    // a stray quote inside an unquoted run is taken as part of it
    if (!quoted && n > 1 && $urandom_range(0, 9) == 0) draft.push_back(vte_pkg::CH_QUOTE);
  endtask

  task automatic ship_body(input bit drain);
    for (int i = 0; i < draft.size(); i++)
      body_q.push_back(body_item_t'{draft[i], i == draft.size() - 1, drain && i == 0});
    draft.delete();
  endtask

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push      <= 1'b0;
      in_body_byte <= 8'h00;
      in_body_last <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        parse_body_byte(in_body_byte, in_body_last);
        bytes_taken++;
      end
      if (!(in_push && in_full)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_push <= 1'b0;
        end else if (body_q.size() != 0 &&
                     !(body_q[0].drain_first && token_chars_due.size() != 0)) begin
          nxt = body_q.pop_front();
          in_push      <= 1'b1;
          in_body_byte <= nxt.b;
          in_body_last <= nxt.fin;
          if (burst_left == 0) burst_left = $urandom_range(1, 48);
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else if (!hold_done && bytes_taken >= 150) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        pop_mode  = $urandom_range(0, 2);
        mode_left = $urandom_range(4, 40);
      end else begin
        mode_left--;
      end
      case (pop_mode)
        0:       out_pop <= 1'b1;
        1:       out_pop <= 1'($urandom_range(0, 1));
        default: out_pop <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (token_chars_due.size() == 0) begin
        report("unexpected item", out_token_char, 8'h00);
      end else begin
        want = token_chars_due.pop_front();
        if (out_token_char !== want.ch) report("token_char", out_token_char, want.ch);
        if (out_token_length !== want.len)
          report("token_length", 8'(out_token_length), 8'(want.len));
        if (out_parse_status !== want.st)
          report("parse_status", 8'(out_parse_status), 8'(want.st));
        if (out_run_last !== want.fin) report("run_last", 8'(out_run_last), 8'(want.fin));
      end
    end
  end

  initial begin
    int unsigned counted;
    int kind;
    int r;
    bit limit_done;
    bit drain_done;
    counted    = 0;
    limit_done = 1'b0;
    drain_done = 1'b0;

    // directed bodies
    draft.push_back(8'h00);
    ship_body(1'b0);
    put_str("a");
    ship_body(1'b0);
    draft.push_back(vte_pkg::CH_QUOTE);
    ship_body(1'b0);
    draft.push_back(vte_pkg::CH_QUOTE);
    draft.push_back(vte_pkg::CH_QUOTE);
    ship_body(1'b0);
    draft.push_back(8'hff);
    ship_body(1'b0);
    put_str("a");
    draft.push_back(vte_pkg::CH_QUOTE);
    put_str("b");
    ship_body(1'b0);
    put_str("v1");
    draft.push_back(8'h09);
    put_str("x");
    ship_body(1'b0);
    put_str("a");
    draft.push_back(8'h00);
    draft.push_back(8'h80);
    ship_body(1'b0);
    put_str("\"version\"");
    ship_body(1'b0);

    while (counted < RANDOM_ITEMS) begin
      if (!limit_done && counted >= 100) begin
        limit_done = 1'b1;
        // bytes past the text limit are dropped
        put_str("\"version\": \"1.2");
        put_ws(BODY_MAX - 16);
        put_str("\"x");
        counted += draft.size();
        ship_body(1'b0);
      end
      kind = $urandom_range(0, 8);
      if (kind <= 3) begin
        r = $urandom_range(0, 3);
        if (r == 1) put_str("\"ver");
        else if (r == 2) put_str("x\"\"");
        else if (r == 3) put_noise($urandom_range(1, 4));
        put_str("\"version\"");
        r = $urandom_range(0, 15);
        put_ws($urandom_range(0, 2));
        if (r != 0) draft.push_back(vte_pkg::CH_COLON);
        put_ws($urandom_range(0, 2));
        if (r > 1) begin
          draft.push_back(vte_pkg::CH_QUOTE);
          put_token(pick_len(), 1'b1);
          if (r != 2) begin
            draft.push_back(vte_pkg::CH_QUOTE);
            put_noise($urandom_range(0, 3));
          end
        end
      end else if (kind <= 5) begin
        put_ws($urandom_range(0, 3));
        draft.push_back(vte_pkg::CH_QUOTE);
        put_token(pick_len(), 1'b1);
        if ($urandom_range(0, 7) != 0) draft.push_back(vte_pkg::CH_QUOTE);
        put_noise($urandom_range(0, 3));
      end else if (kind <= 7) begin
        put_ws($urandom_range(0, 3));
        put_token(pick_len(), 1'b0);
        if ($urandom_range(0, 1) == 0) begin
          put_ws($urandom_range(1, 2));
          put_noise($urandom_range(0, 3));
        end
      end else begin
        repeat ($urandom_range(1, 10)) draft.push_back(8'($urandom_range(0, 255)));
      end
      if (draft.size() == 0) put_noise(1);
      if ($urandom_range(0, 11) == 0) draft[$urandom_range(0, draft.size() - 1)] = 8'h00;
      counted += draft.size();
      r = (counted == draft.size()) || (!drain_done && counted >= 180);
      if (counted >= 180) drain_done = 1'b1;
      ship_body(r != 0);
    end
    items_total = body_q.size();

    while (bytes_taken < items_total) @(posedge clk);
    while (token_chars_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
